### hw/rtl/char_lcd_bus_sequencer_top_assert.svh
// Assertion macros for the character-LCD bus sequencer checker.
// No dependencies; included by the checker file only.
`ifndef CHAR_LCD_BUS_SEQUENCER_TOP_ASSERT_SVH
`define CHAR_LCD_BUS_SEQUENCER_TOP_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define CLBS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition holds in the cycle after the trigger.
`define CLBS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/clbs_pkg.sv
// Shared types and constants for the character-LCD bus sequencer.
// No dependencies; imported by every module of the block.
package clbs_pkg;

    localparam int BYTE_W         = 8;
    localparam int NIB_W          = 4;
    localparam int WAIT_W         = 16;
    localparam int EN_W           = 8;
    localparam int DELAY_BITS_DEF = 16;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_FOUR_BIT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UPPER_LANE = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_BUSY  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_EN_TICKS   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_WAIT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_WAIT  = 3'd5;

    localparam logic [EN_W-1:0]   EN_TICKS_RST   = 8'd1;
    localparam logic [WAIT_W-1:0] SHORT_WAIT_RST = 16'd50;
    localparam logic [WAIT_W-1:0] LONG_WAIT_RST  = 16'd2000;

    // Commands whose upper six bits are clear (clear display, return home)
    localparam logic [BYTE_W-1:0] LONG_CMD_MASK = 8'hFC;
    localparam logic [BYTE_W-1:0] BUSY_MASK     = 8'h80;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                is_tick;
        logic                is_data;
        logic [BYTE_W-1:0]   value;
        logic [BYTE_W-1:0]   pins;
    } clbs_item_t;

    typedef struct packed {
        logic       valid;
        clbs_item_t item;
    } clbs_queue_out_t;

endpackage

### hw/rtl/char_lcd_bus_sequencer_top.sv
// Character-LCD bus sequencer: top level.
// Input word: a write request or a 1 us tick carrying sampled data lines.
// Output word: bus levels after that input word is handled, plus ready,
//   accepted flag and the last status read.
// Channels: in_valid/in_stall and out_valid/out_stall; a word moves on a
//   rising edge with valid high and stall low. cfg_valid/cfg_ready writes
//   register cfg_index with cfg_data; cfg_ready is always high.
// Throughput: one input word per cycle while out_stall stays low, set by the
//   sequencer step in the back end. The input word is written into a slot of
//   the two-entry queue, then popped into the back-end result registers.
// Each input word yields exactly one result word, in order.
// When the receiver stalls, the result word holds, the back end stops
//   draining the queue, and in_stall rises once both queue entries are full.
// Reset: queue empty, no result pending, phase idle, lines driven low,
//   RS, RW and E low, registers at their defaults (8-bit mode, timed waits,
//   E one tick, short wait 50 ticks, long wait 2000 ticks).
// Depends on clbs_pkg, clbs_front, clbs_back.
module char_lcd_bus_sequencer_top #(
    parameter int DELAY_BITS = clbs_pkg::DELAY_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             req_type,
    input  logic                             is_data,
    input  logic [clbs_pkg::BYTE_W-1:0]      value_byte,
    input  logic [clbs_pkg::BYTE_W-1:0]      pins_in,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [clbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [clbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [clbs_pkg::BYTE_W-1:0]      data_out,
    output logic                             data_drive,
    output logic                             rs_pin,
    output logic                             rw_pin,
    output logic                             en_pin,
    output logic                             ready_res,
    output logic                             accepted,
    output logic [clbs_pkg::BYTE_W-1:0]      status_byte
);
    import clbs_pkg::*;

    clbs_queue_out_t q_out;
    logic            q_pop;

    clbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .is_data    (is_data),
        .value_byte (value_byte),
        .pins_in    (pins_in),
        .q_out      (q_out),
        .q_pop      (q_pop)
    );

    clbs_back #(
        .DELAY_BITS (DELAY_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_out       (q_out),
        .q_pop       (q_pop),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_out    (data_out),
        .data_drive  (data_drive),
        .rs_pin      (rs_pin),
        .rw_pin      (rw_pin),
        .en_pin      (en_pin),
        .ready_res   (ready_res),
        .accepted    (accepted),
        .status_byte (status_byte)
    );

endmodule

### hw/rtl/clbs_front.sv
// Front end: takes input words, classifies them and holds them in a short queue.
// Depends on clbs_pkg.
module clbs_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic                     req_type,
    input  logic                     is_data,
    input  logic [clbs_pkg::BYTE_W-1:0] value_byte,
    input  logic [clbs_pkg::BYTE_W-1:0] pins_in,
    output clbs_pkg::clbs_queue_out_t q_out,
    input  logic                     q_pop
);
    import clbs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    clbs_item_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    clbs_item_t             item_in;
    logic                   push;
    logic                   pop;

    // Ticks carry only the sampled lines; requests carry only flag and byte.
    always_comb
    begin
        item_in.is_tick = req_type;
        item_in.is_data = req_type ? 1'b0 : is_data;
        item_in.value   = req_type ? '0 : value_byte;
        item_in.pins    = req_type ? pins_in : '0;
    end

    assign in_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign pop      = q_pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign q_out.valid = (count_reg != '0);
    assign q_out.item  = slot_reg[rd_ptr_reg];

endmodule

### hw/rtl/clbs_back.sv
// Back end: register file, bus sequencer; one word per unstalled cycle, levels held as outputs.
// Depends on clbs_pkg.
module clbs_back #(
    parameter int DELAY_BITS = clbs_pkg::DELAY_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  clbs_pkg::clbs_queue_out_t     q_out,
    output logic                          q_pop,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [clbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [clbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [clbs_pkg::BYTE_W-1:0]   data_out,
    output logic                          data_drive,
    output logic                          rs_pin,
    output logic                          rw_pin,
    output logic                          en_pin,
    output logic                          ready_res,
    output logic                          accepted,
    output logic [clbs_pkg::BYTE_W-1:0]   status_byte
);
    import clbs_pkg::*;

    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_IDLE  = 4'd0;
    localparam logic [PH_W-1:0] PH_WEN1  = 4'd1;
    localparam logic [PH_W-1:0] PH_WPRE2 = 4'd2;
    localparam logic [PH_W-1:0] PH_WEN2  = 4'd3;
    localparam logic [PH_W-1:0] PH_WAIT  = 4'd4;
    localparam logic [PH_W-1:0] PH_RPRE1 = 4'd5;
    localparam logic [PH_W-1:0] PH_REN1  = 4'd6;
    localparam logic [PH_W-1:0] PH_RPRE2 = 4'd7;
    localparam logic [PH_W-1:0] PH_REN2  = 4'd8;

    // Configuration registers
    logic               four_bit_reg;
    logic               upper_lane_reg;
    logic               poll_busy_reg;
    logic [EN_W-1:0]    en_ticks_reg;
    logic [WAIT_W-1:0]  short_wait_reg;
    logic [WAIT_W-1:0]  long_wait_reg;

    // Sequencer state
    logic [PH_W-1:0]       phase_reg, phase_next;
    logic [DELAY_BITS-1:0] cnt_reg, cnt_next;
    logic [BYTE_W-1:0]     held_byte_reg, held_byte_next;
    logic                  held_is_data_reg, held_is_data_next;
    logic [BYTE_W-1:0]     lines_reg, lines_next;
    logic [BYTE_W-1:0]     asm_reg, asm_next;
    logic [BYTE_W-1:0]     status_reg, status_next;
    logic                  drive_reg, drive_next;
    logic                  rs_reg, rs_next;
    logic                  rw_reg, rw_next;
    logic                  en_reg, en_next;
    logic                  acc_reg, acc_next;
    logic                  out_valid_reg, out_valid_next;

    logic                  pop;
    clbs_item_t            item;
    logic [DELAY_BITS-1:0] cnt_dec;
    logic                  cnt_last;
    logic [DELAY_BITS-1:0] en_load;
    logic [WAIT_W-1:0]     wait_sel;
    logic [DELAY_BITS-1:0] wait_load;
    logic [BYTE_W-1:0]     rd_status;

    function automatic logic [BYTE_W-1:0] put_nib(input logic [BYTE_W-1:0] lines,
                                                  input logic [NIB_W-1:0]  nib,
                                                  input logic              upper);
        logic [BYTE_W-1:0] res;
        res = upper ? {nib, lines[NIB_W-1:0]} : {lines[BYTE_W-1:NIB_W], nib};
        return res;
    endfunction

    function automatic logic [NIB_W-1:0] get_nib(input logic [BYTE_W-1:0] pins,
                                                 input logic              upper);
        logic [NIB_W-1:0] res;
        res = upper ? pins[BYTE_W-1:NIB_W] : pins[NIB_W-1:0];
        return res;
    endfunction

    // The user makes register writes only while idle; the block does not check or enforce this.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            four_bit_reg   <= 1'b0;
            upper_lane_reg <= 1'b0;
            poll_busy_reg  <= 1'b0;
            en_ticks_reg   <= EN_TICKS_RST;
            short_wait_reg <= SHORT_WAIT_RST;
            long_wait_reg  <= LONG_WAIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FOUR_BIT:   four_bit_reg   <= cfg_data[0];
                CFG_UPPER_LANE: upper_lane_reg <= cfg_data[0];
                CFG_POLL_BUSY:  poll_busy_reg  <= cfg_data[0];
                CFG_EN_TICKS:   en_ticks_reg   <= cfg_data[EN_W-1:0];
                CFG_SHORT_WAIT: short_wait_reg <= cfg_data[WAIT_W-1:0];
                CFG_LONG_WAIT:  long_wait_reg  <= cfg_data[WAIT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Take the next queued word whenever the result slot is free or drains.
    assign item  = q_out.item;
    assign pop   = q_out.valid && (!out_valid_reg || !out_stall);
    assign q_pop = pop;

    assign cnt_dec  = (cnt_reg == '0) ? '0 : cnt_reg - 1'b1;
    assign cnt_last = (cnt_dec == '0);
    assign en_load  = (en_ticks_reg == '0) ? DELAY_BITS'(1) : DELAY_BITS'(en_ticks_reg);

    always_comb
    begin
        wait_sel  = (!held_is_data_reg && ((held_byte_reg & LONG_CMD_MASK) == '0))
                    ? long_wait_reg : short_wait_reg;
        // Saturate to the counter range.
        wait_load = (|(32'(wait_sel) >> DELAY_BITS)) ? '1 : DELAY_BITS'(wait_sel);
    end

    always_comb
    begin
        phase_next        = phase_reg;
        cnt_next          = cnt_reg;
        held_byte_next    = held_byte_reg;
        held_is_data_next = held_is_data_reg;
        lines_next        = lines_reg;
        asm_next          = asm_reg;
        status_next       = status_reg;
        drive_next        = drive_reg;
        rs_next           = rs_reg;
        rw_next           = rw_reg;
        en_next           = en_reg;
        acc_next          = acc_reg;
        rd_status         = 8'h00;
        out_valid_next    = out_valid_reg && out_stall;

        if (pop)
        begin
            out_valid_next = 1'b1;
            acc_next       = 1'b0;
            if (item.is_tick)
            begin
                case (phase_reg)
                    PH_WEN1:
                    begin
                        cnt_next = cnt_dec;
                        if (cnt_last)
                        begin
                            en_next    = 1'b0;
                            lines_next = put_nib(lines_reg, held_byte_reg[NIB_W-1:0],
                                                 upper_lane_reg);
                            phase_next = PH_WPRE2;
                        end
                    end
                    PH_WPRE2:
                    begin
                        en_next    = 1'b1;
                        cnt_next   = en_load;
                        phase_next = PH_WEN2;
                    end
                    PH_WEN2:
                    begin
                        cnt_next = cnt_dec;
                        if (cnt_last)
                        begin
                            en_next = 1'b0;
                            if (poll_busy_reg)
                            begin
                                drive_next = 1'b0;
                                rs_next    = 1'b0;
                                rw_next    = 1'b1;
                                phase_next = PH_RPRE1;
                            end
                            else
                            begin
                                cnt_next   = wait_load;
                                phase_next = (wait_load == '0) ? PH_IDLE : PH_WAIT;
                            end
                        end
                    end
                    PH_WAIT:
                    begin
                        cnt_next = cnt_dec;
                        if (cnt_last)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_RPRE1:
                    begin
                        en_next    = 1'b1;
                        cnt_next   = en_load;
                        phase_next = PH_REN1;
                    end
                    PH_REN1:
                    begin
                        cnt_next = cnt_dec;
                        if (cnt_last)
                        begin
                            en_next = 1'b0;
                            if (four_bit_reg)
                            begin
                                asm_next   = {get_nib(item.pins, upper_lane_reg), 4'h0};
                                phase_next = PH_RPRE2;
                            end
                            else
                            begin
                                status_next = item.pins;
                                phase_next  = ((item.pins & BUSY_MASK) != '0) ? PH_RPRE1 : PH_IDLE;
                            end
                        end
                    end
                    PH_RPRE2:
                    begin
                        en_next    = 1'b1;
                        cnt_next   = en_load;
                        phase_next = PH_REN2;
                    end
                    PH_REN2:
                    begin
                        cnt_next = cnt_dec;
                        if (cnt_last)
                        begin
                            rd_status   = {asm_reg[BYTE_W-1:NIB_W],
                                           get_nib(item.pins, upper_lane_reg)};
                            en_next     = 1'b0;
                            asm_next    = rd_status;
                            status_next = rd_status;
                            phase_next  = ((rd_status & BUSY_MASK) != '0) ? PH_RPRE1 : PH_IDLE;
                        end
                    end
                    PH_IDLE:
                    begin
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            else if (phase_reg == PH_IDLE)
            begin
                acc_next          = 1'b1;
                held_is_data_next = item.is_data;
                held_byte_next    = item.value;
                drive_next        = 1'b1;
                rs_next           = item.is_data;
                rw_next           = 1'b0;
                en_next           = 1'b1;
                cnt_next          = en_load;
                if (four_bit_reg)
                begin
                    lines_next = put_nib(lines_reg, item.value[BYTE_W-1:NIB_W], upper_lane_reg);
                    phase_next = PH_WEN1;
                end
                else
                begin
                    lines_next = item.value;
                    phase_next = PH_WEN2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            cnt_reg          <= '0;
            held_byte_reg    <= '0;
            held_is_data_reg <= 1'b0;
            lines_reg        <= '0;
            asm_reg          <= '0;
            status_reg       <= '0;
            drive_reg        <= 1'b1;
            rs_reg           <= 1'b0;
            rw_reg           <= 1'b0;
            en_reg           <= 1'b0;
            acc_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            cnt_reg          <= cnt_next;
            held_byte_reg    <= held_byte_next;
            held_is_data_reg <= held_is_data_next;
            lines_reg        <= lines_next;
            asm_reg          <= asm_next;
            status_reg       <= status_next;
            drive_reg        <= drive_next;
            rs_reg           <= rs_next;
            rw_reg           <= rw_next;
            en_reg           <= en_next;
            acc_reg          <= acc_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // The state registers double as the result word; all but out_valid move only on a pop.
    assign out_valid   = out_valid_reg;
    assign data_out    = lines_reg;
    assign data_drive  = drive_reg;
    assign rs_pin      = rs_reg;
    assign rw_pin      = rw_reg;
    assign en_pin      = en_reg;
    assign ready_res   = (phase_reg == PH_IDLE);
    assign accepted    = acc_reg;
    assign status_byte = status_reg;

endmodule

### hw/rtl/clbs_checker.sv
// Port-level checker for the character-LCD bus sequencer, bound to the top level.
// Depends on clbs_pkg and char_lcd_bus_sequencer_top_assert.svh.
`include "char_lcd_bus_sequencer_top_assert.svh"

module clbs_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [clbs_pkg::BYTE_W-1:0]      data_out,
    input logic                             data_drive,
    input logic                             rw_pin,
    input logic                             en_pin,
    input logic                             ready_res,
    input logic                             accepted,
    input logic [clbs_pkg::BYTE_W-1:0]      status_byte
);
    import clbs_pkg::*;

    // Stalled result word holds.
    `CLBS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(data_out) && $stable(status_byte) && $stable(accepted)
            && $stable(en_pin),
        "result word changed while stalled")

    // A taken request starts an E pulse with the bus driven for writing.
    `CLBS_ASSERT_NOW(a_acc_start, clk, rst_n, out_valid && accepted,
        !ready_res && en_pin && data_drive && !rw_pin,
        "taken request did not start a write pulse")

    // Lines are released exactly while reading.
    `CLBS_ASSERT_NOW(a_rw_drive, clk, rst_n, out_valid, rw_pin != data_drive,
        "RW and line drive disagree")

    // Idle never leaves E high.
    `CLBS_ASSERT_NOW(a_idle_en, clk, rst_n, out_valid && ready_res, !en_pin,
        "E high while idle")

endmodule

bind char_lcd_bus_sequencer_top clbs_checker u_clbs_checker (.*);

### verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for char_lcd_bus_sequencer_top: queue-fed driver, output monitor,
// in-bench bus sequencer predictor. Depends on clbs_pkg and the RTL top only.
module tb;
    import clbs_pkg::*;

    localparam int QUIET_LIMIT   = 3000;
    localparam int RX_HOLD_CYC   = 400;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_BUDGET  = 65;
    localparam int BUSY_PCT      = 40;
    localparam int POLL_TICK_CAP = 3000;

    typedef enum logic [3:0] {
        BUS_IDLE, BUS_WR_EN1, BUS_WR_GAP, BUS_WR_EN2, BUS_SETTLE,
        BUS_RD_GAP1, BUS_RD_EN1, BUS_RD_GAP2, BUS_RD_EN2
    } bus_phase_t;

    typedef struct packed {
        bus_phase_t          phase;
        logic [WAIT_W-1:0]   ticks;
        logic [BYTE_W-1:0]   byte_held;
        logic                data_held;
        logic [BYTE_W-1:0]   lines;
        logic [BYTE_W-1:0]   rd_asm;
        logic [BYTE_W-1:0]   status;
        logic                drive;
        logic                rs;
        logic                rw;
        logic                en;
    } lcd_bus_t;

    typedef struct packed {
        logic                four;
        logic                upper;
        logic                poll;
        logic [EN_W-1:0]     en_ticks;
        logic [WAIT_W-1:0]   short_wait;
        logic [WAIT_W-1:0]   long_wait;
    } lcd_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   data_out;
        logic                data_drive;
        logic                rs;
        logic                rw;
        logic                en;
        logic                ready;
        logic                accepted;
        logic [BYTE_W-1:0]   status;
    } bus_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic req_type = 1'b0;
    logic is_data = 1'b0;
    logic [BYTE_W-1:0] value_byte = '0;
    logic [BYTE_W-1:0] pins_in = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [BYTE_W-1:0] data_out;
    logic data_drive;
    logic rs_pin;
    logic rw_pin;
    logic en_pin;
    logic ready_res;
    logic accepted;
    logic [BYTE_W-1:0] status_byte;

    lcd_cfg_t lcd_cfg;
    lcd_bus_t gen_bus;
    lcd_bus_t acc_bus;
    clbs_item_t word_backlog[$];
    bus_word_t bus_due_q[$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic tx_pause = 1'b0;
    logic rx_hold_go = 1'b0;
    int rx_hold_left = 0;
    int quiet_cyc = 0;
    int n_err = 0;
    int n_checked = 0;
    int n_sent = 0;
    int n_live = 0;

    char_lcd_bus_sequencer_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .is_data     (is_data),
        .value_byte  (value_byte),
        .pins_in     (pins_in),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .data_out    (data_out),
        .data_drive  (data_drive),
        .rs_pin      (rs_pin),
        .rw_pin      (rw_pin),
        .en_pin      (en_pin),
        .ready_res   (ready_res),
        .accepted    (accepted),
        .status_byte (status_byte)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic logic [BYTE_W-1:0] lane_put(logic [BYTE_W-1:0] lines,
                                                   logic [NIB_W-1:0] nib);
        return lcd_cfg.upper ? {nib, lines[3:0]} : {lines[7:4], nib};
    endfunction

    function automatic logic [NIB_W-1:0] lane_get(logic [BYTE_W-1:0] pins);
        return lcd_cfg.upper ? pins[7:4] : pins[3:0];
    endfunction

    function automatic void pulse_start(inout lcd_bus_t s);
        s.en = 1'b1;
        s.ticks = (lcd_cfg.en_ticks == '0) ? 16'd1 : {8'd0, lcd_cfg.en_ticks};
    endfunction

    function automatic void status_done(inout lcd_bus_t s, input logic [BYTE_W-1:0] st);
        s.en = 1'b0;
        s.status = st;
        s.phase = ((st & BUSY_MASK) != '0) ? BUS_RD_GAP1 : BUS_IDLE;
    endfunction

    // Advance the bus sequencer by one input word; return the bus levels after it.
    function automatic bus_word_t lcd_advance(inout lcd_bus_t s, input clbs_item_t it);
        bus_word_t r;
        logic [WAIT_W-1:0] w;
        logic took;
        took = 1'b0;
        if (it.is_tick)
        begin
            if (s.phase inside {BUS_WR_EN1, BUS_WR_EN2, BUS_SETTLE, BUS_RD_EN1, BUS_RD_EN2}
                && s.ticks != '0)
                s.ticks = s.ticks - 1'b1;
            case (s.phase)
                BUS_WR_EN1:
                    if (s.ticks == '0)
                    begin
                        s.en = 1'b0;
                        s.lines = lane_put(s.lines, s.byte_held[3:0]);
                        s.phase = BUS_WR_GAP;
                    end
                BUS_WR_GAP:
                begin
                    pulse_start(s);
                    s.phase = BUS_WR_EN2;
                end
                BUS_WR_EN2:
                    if (s.ticks == '0)
                    begin
                        s.en = 1'b0;
                        if (lcd_cfg.poll)
                        begin
                            s.drive = 1'b0;
                            s.rs = 1'b0;
                            s.rw = 1'b1;
                            s.phase = BUS_RD_GAP1;
                        end
                        else
                        begin
                            // clear and home commands take the long wait
                            if (!s.data_held && (s.byte_held & LONG_CMD_MASK) == '0)
                                w = lcd_cfg.long_wait;
                            else
                                w = lcd_cfg.short_wait;
                            s.ticks = w;
                            s.phase = (w == '0) ? BUS_IDLE : BUS_SETTLE;
                        end
                    end
                BUS_SETTLE:
                    if (s.ticks == '0)
                        s.phase = BUS_IDLE;
                BUS_RD_GAP1:
                begin
                    pulse_start(s);
                    s.phase = BUS_RD_EN1;
                end
                BUS_RD_EN1:
                    if (s.ticks == '0)
                    begin
                        if (lcd_cfg.four)
                        begin
                            s.en = 1'b0;
                            s.rd_asm = {lane_get(it.pins), 4'h0};
                            s.phase = BUS_RD_GAP2;
                        end
                        else
                        begin
                            status_done(s, it.pins);
                        end
                    end
                BUS_RD_GAP2:
                begin
                    pulse_start(s);
                    s.phase = BUS_RD_EN2;
                end
                BUS_RD_EN2:
                    if (s.ticks == '0)
                    begin
                        s.rd_asm[3:0] = lane_get(it.pins);
                        status_done(s, s.rd_asm);
                    end
                default: ;
            endcase
        end
        else if (s.phase == BUS_IDLE)
        begin
            took = 1'b1;
            s.data_held = it.is_data;
            s.byte_held = it.value;
            s.drive = 1'b1;
            s.rs = it.is_data;
            s.rw = 1'b0;
            if (lcd_cfg.four)
            begin
                s.lines = lane_put(s.lines, it.value[7:4]);
                s.phase = BUS_WR_EN1;
            end
            else
            begin
                s.lines = it.value;
                s.phase = BUS_WR_EN2;
            end
            pulse_start(s);
        end
        r.data_out = s.lines;
        r.data_drive = s.drive;
        r.rs = s.rs;
        r.rw = s.rw;
        r.en = s.en;
        r.ready = (s.phase == BUS_IDLE);
        r.accepted = took;
        r.status = s.status;
        return r;
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk)
    begin : drv
        logic took;
        if (rst_n)
        begin
            took = in_valid && !in_stall;
            if (took)
            begin
                bus_due_q.push_back(lcd_advance(acc_bus, word_backlog[0]));
                void'(word_backlog.pop_front());
                n_sent++;
            end
            if (!in_valid || took)
            begin
                if (word_backlog.size() > 0 && !tx_pause
                    && $urandom_range(99, 0) >= tx_idle_pct)
                begin
                    in_valid <= 1'b1;
                    req_type <= word_backlog[0].is_tick;
                    is_data <= word_backlog[0].is_data;
                    value_byte <= word_backlog[0].value;
                    pins_in <= word_backlog[0].pins;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver stall and long hold-off ----------------

    always @(posedge clk)
    begin
        if (rx_hold_go)
            rx_hold_left <= RX_HOLD_CYC;
        else if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
        out_stall <= rx_hold_go || rx_hold_left > 1 || $urandom_range(99, 0) < rx_idle_pct;
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin : mon
        bus_word_t got;
        bus_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{data_out, data_drive, rs_pin, rw_pin, en_pin, ready_res, accepted,
                    status_byte};
            if (bus_due_q.size() == 0)
            begin
                n_err++;
                if (n_err <= 10)
                    $display("[%0t] unexpected result word data=%h", $realtime, data_out);
            end
            else
            begin
                want = bus_due_q.pop_front();
                n_checked++;
                if (got.data_out !== want.data_out || got.data_drive !== want.data_drive
                    || got.rs !== want.rs || got.rw !== want.rw || got.en !== want.en
                    || got.ready !== want.ready || got.accepted !== want.accepted
                    || got.status !== want.status)
                begin
                    n_err++;
                    if (n_err <= 10)
                    begin
                        $display("[%0t] word %0d mismatch: want data=%h drv=%b rs=%b rw=%b en=%b rdy=%b acc=%b st=%h",
                                 $realtime, n_checked, want.data_out, want.data_drive,
                                 want.rs, want.rw, want.en, want.ready, want.accepted,
                                 want.status);
                        $display("    got data=%h drv=%b rs=%b rw=%b en=%b rdy=%b acc=%b st=%h",
                                 got.data_out, got.data_drive, got.rs, got.rw,
                                 got.en, got.ready, got.accepted, got.status);
                    end
                end
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)
                || (cfg_valid && cfg_ready))
                quiet_cyc <= 0;
            else
                quiet_cyc <= quiet_cyc + 1;
            if (quiet_cyc >= QUIET_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", QUIET_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FOUR_BIT:   lcd_cfg.four = val[0];
            CFG_UPPER_LANE: lcd_cfg.upper = val[0];
            CFG_POLL_BUSY:  lcd_cfg.poll = val[0];
            CFG_EN_TICKS:   lcd_cfg.en_ticks = val[EN_W-1:0];
            CFG_SHORT_WAIT: lcd_cfg.short_wait = val;
            CFG_LONG_WAIT:  lcd_cfg.long_wait = val;
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic bus_setup(input logic four, input logic upper, input logic poll,
                             input logic [EN_W-1:0] en_t, input logic [WAIT_W-1:0] sw,
                             input logic [WAIT_W-1:0] lw);
        cfg_write(CFG_FOUR_BIT, {15'd0, four});
        cfg_write(CFG_UPPER_LANE, {15'd0, upper});
        cfg_write(CFG_POLL_BUSY, {15'd0, poll});
        cfg_write(CFG_EN_TICKS, {8'd0, en_t});
        cfg_write(CFG_SHORT_WAIT, sw);
        cfg_write(CFG_LONG_WAIT, lw);
    endtask

    function automatic clbs_item_t rand_word();
        clbs_item_t it;
        it.is_tick = 1'($urandom_range(1, 0));
        it.is_data = 1'($urandom_range(1, 0));
        it.value = 8'($urandom_range(255, 0));
        it.pins = 8'($urandom_range(255, 0));
        return it;
    endfunction

    // Queue a word, tracking the look-ahead copy of the bus so transfers run to idle.
    task automatic push_word(input clbs_item_t it);
        bus_word_t r;
        logic was_idle;
        was_idle = (gen_bus.phase == BUS_IDLE);
        r = lcd_advance(gen_bus, it);
        if (r.accepted || (it.is_tick && !was_idle))
            n_live++;
        word_backlog.push_back(it);
    endtask

    // One write request followed by ticks until the bus is idle again; busy_pct sets
    // how often a status read sees the busy flag, noise_pct how often a stray word lands.
    task automatic gen_transfer(input logic dat, input logic [BYTE_W-1:0] val,
                                input int busy_pct, input int noise_pct);
        clbs_item_t it;
        int ticks;
        logic busy;
        ticks = 0;
        if ($urandom_range(99, 0) < noise_pct)
        begin
            it = rand_word();
            it.is_tick = 1'b1;
            push_word(it);
        end
        it = rand_word();
        it.is_tick = 1'b0;
        it.is_data = dat;
        it.value = val;
        push_word(it);
        while (gen_bus.phase != BUS_IDLE)
        begin
            if ($urandom_range(99, 0) < noise_pct)
            begin
                it = rand_word();
                it.is_tick = 1'b0;
                push_word(it);
            end
            it = rand_word();
            it.is_tick = 1'b1;
            // busy bit sits on line 7 or line 3 depending on lane and width
            busy = ticks < POLL_TICK_CAP && $urandom_range(99, 0) < busy_pct;
            it.pins[7] = busy;
            it.pins[3] = busy;
            push_word(it);
            ticks++;
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (word_backlog.size() != 0 || bus_due_q.size() != 0 || in_valid);
    endtask

    initial
    begin : main
        int p;
        int start;
        logic [BYTE_W-1:0] v;
        lcd_cfg = '{1'b0, 1'b0, 1'b0, EN_TICKS_RST, SHORT_WAIT_RST, LONG_WAIT_RST};
        gen_bus = '0;
        gen_bus.phase = BUS_IDLE;
        gen_bus.drive = 1'b1;
        acc_bus = gen_bus;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: one data write and one ordinary command
        tx_idle_pct = 9;
        rx_idle_pct = 84;
        gen_transfer(1'b1, 8'h41, 0, 0);
        gen_transfer(1'b0, 8'h38, 0, 0);
        wait_drained();

        // directed: zero E width, zero short wait, ignored words, field extremes
        bus_setup(1'b0, 1'b0, 1'b0, 8'd0, 16'd0, 16'd2);
        push_word('{1'b1, 1'b0, 8'h00, 8'hFF});
        push_word('{1'b1, 1'b1, 8'hFF, 8'h00});
        gen_transfer(1'b1, 8'hFF, 0, 50);
        gen_transfer(1'b0, 8'h00, 0, 50);
        gen_transfer(1'b0, 8'h04, 0, 0);
        wait_drained();
        bus_setup(1'b1, 1'b1, 1'b1, 8'd1, 16'd0, 16'd0);
        gen_transfer(1'b1, 8'hA5, 50, 0);
        gen_transfer(1'b0, 8'h5A, 50, 0);
        wait_drained();
        bus_setup(1'b1, 1'b0, 1'b1, 8'd2, 16'd1, 16'd1);
        gen_transfer(1'b0, 8'h3C, 50, 0);
        wait_drained();

        // widest E pulse and a long wait that uses the upper byte of the register
        bus_setup(1'b0, 1'b1, 1'b0, 8'd255, 16'd3, 16'h0100);
        gen_transfer(1'b0, 8'h02, 0, 0);
        wait_drained();

        for (p = 0; p < RAND_PHASES; p++)
        begin
            tx_idle_pct = (p < 4) ? 9 : (p < 8) ? 84 : 0;
            rx_idle_pct = (p < 4) ? 84 : (p < 8) ? 9 : 0;
            bus_setup(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                      1'($urandom_range(1, 0)),
                      (p == 7) ? 8'd0 : 8'($urandom_range(3, 1)),
                      16'($urandom_range(6, 0)), 16'($urandom_range(10, 0)));
            start = n_live;
            while (n_live - start < PHASE_BUDGET)
            begin
                v = ($urandom_range(4, 0) == 0) ? 8'($urandom_range(3, 0))
                                                : 8'($urandom_range(255, 0));
                gen_transfer(1'($urandom_range(1, 0)), v, BUSY_PCT, 10);
            end
            if (p == 1)
            begin
                // long receiver hold-off while the sender keeps offering words
                rx_hold_go = 1'b1;
                @(negedge clk);
                rx_hold_go = 1'b0;
            end
            if (p == 5)
            begin
                // sender holds until every result is back, then resumes
                while (word_backlog.size() > PHASE_BUDGET / 2)
                    @(negedge clk);
                tx_pause = 1'b1;
                while (bus_due_q.size() != 0 || in_valid)
                    @(negedge clk);
                tx_pause = 1'b0;
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        n_err += bus_due_q.size();
        $display("Sent %0d words (%0d drove the bus), checked %0d result words.",
                 n_sent, n_live, n_checked);
        $display("Covered 8/4-bit lanes, polled and timed waits, E width 0..255, stray words.");
        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
